### rtl/core/node_pool_list_with_max_query_assert.svh
// ----------------------------------------------------------------------------
// node_pool_list_with_max_query_assert.svh
// Assertion macros used by the node pool list datapath (nplmq_dp).
// ----------------------------------------------------------------------------
`ifndef NODE_POOL_LIST_WITH_MAX_QUERY_ASSERT_SVH
`define NODE_POOL_LIST_WITH_MAX_QUERY_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NPLMQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("nplmq: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define NPLMQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("nplmq: next-cycle check failed");

`endif

### rtl/core/nplmq_pkg.sv
// ----------------------------------------------------------------------------
// nplmq_pkg
// Types, codes and constants shared by the node pool list block.
// ----------------------------------------------------------------------------
package nplmq_pkg;

	localparam int DEF_POOL_NODES = 16;

	localparam int CODE_W = 16;
	localparam int SAL_W  = 24;
	localparam int MAX_W  = SAL_W + 1;
	localparam int STAT_W = 2;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_FIND   = 1'b1;

	localparam logic [STAT_W-1:0] STAT_INS_DONE = 2'd0;
	localparam logic [STAT_W-1:0] STAT_INS_FULL = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FIND     = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_WR,
		ST_RESULT,
		ST_WALK,
		ST_EMIT
	} nplmq_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic ins_commit;
		logic res_load;
		logic walk;
		logic emit;
	} nplmq_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic in_find;
		logic free_nil;
		logic head_nil;
		logic walk_done;
		logic emit_done;
		logic out_free;
	} nplmq_st_t;

endpackage

### rtl/core/nplmq_ram.sv
// ----------------------------------------------------------------------------
// nplmq_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module nplmq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/core/nplmq_ctrl.sv
// ----------------------------------------------------------------------------
// nplmq_ctrl
// Sequencer for insert, list walk and tie-code emission.
// ----------------------------------------------------------------------------
module nplmq_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  nplmq_pkg::nplmq_st_t   st,
	output nplmq_pkg::nplmq_cmd_t  cmd
);

	import nplmq_pkg::*;

	nplmq_state_t state_q;
	nplmq_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (st.in_find) begin
						state_d = st.head_nil ? ST_RESULT : ST_WALK;
					end else begin
						state_d = st.free_nil ? ST_RESULT : ST_INS_WR;
					end
				end
			end
			ST_INS_WR: begin
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (st.out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_WALK: begin
				if (st.walk_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (st.emit_done) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			ST_INS_WR: begin
				cmd.ins_commit = 1'b1;
			end
			ST_RESULT: begin
				cmd.res_load = st.out_free;
			end
			ST_WALK: begin
				cmd.walk = 1'b1;
			end
			ST_EMIT: begin
				cmd.emit = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

### rtl/core/nplmq_dp.sv
// ----------------------------------------------------------------------------
// nplmq_dp
// Node store, list and free heads, maximum tracker, tie stack and the
// result register.
// ----------------------------------------------------------------------------
`include "node_pool_list_with_max_query_assert.svh"

module nplmq_dp #(
	parameter int POOL_NODES = nplmq_pkg::DEF_POOL_NODES
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  nplmq_pkg::nplmq_cmd_t              cmd,
	output nplmq_pkg::nplmq_st_t               st,
	input  logic                               in_find,
	input  logic [nplmq_pkg::CODE_W-1:0]       in_code,
	input  logic [nplmq_pkg::SAL_W-1:0]        in_salary,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [nplmq_pkg::STAT_W-1:0]       out_status,
	output logic signed [nplmq_pkg::MAX_W-1:0] out_max,
	output logic [nplmq_pkg::CODE_W-1:0]       out_code,
	output logic                               out_code_valid,
	output logic                               out_list_empty,
	output logic                               out_pool_full,
	output logic                               out_last
);

	import nplmq_pkg::*;

	localparam int NW  = $clog2(POOL_NODES);
	localparam int LW  = $clog2(POOL_NODES + 1);
	localparam int NRW = LW + CODE_W + SAL_W;
	localparam logic [LW-1:0] NIL = LW'(POOL_NODES);

	// Heads and reset state of the link field.
	logic [LW-1:0]         list_head_q;
	logic [LW-1:0]         free_head_q;
	logic [POOL_NODES-1:0] link_vld_q;

	// Latched input item.
	logic              act_q;
	logic              ins_full_q;
	logic [CODE_W-1:0] code_q;
	logic [SAL_W-1:0]  sal_q;

	// Node read pipeline.
	logic [NW-1:0] rd_node_s1;
	logic          rd_vld_s1;

	// Walk and tie tracking.
	logic [LW-1:0]    steps_q;
	logic             have_q;
	logic [SAL_W-1:0] max_q;
	logic [LW-1:0]    tcnt_q;
	logic             pend_q;
	logic             pend_last_q;

	// Result register.
	logic                     out_valid_q;
	logic [STAT_W-1:0]        out_status_q;
	logic signed [MAX_W-1:0]  out_max_q;
	logic [CODE_W-1:0]        out_code_q;
	logic                     out_code_valid_q;
	logic                     out_list_empty_q;
	logic                     out_pool_full_q;
	logic                     out_last_q;

	logic              node_re;
	logic [NW-1:0]     node_raddr;
	logic [NRW-1:0]    node_wdata;
	logic [NRW-1:0]    node_rdata;
	logic [SAL_W-1:0]  ram_sal;
	logic [CODE_W-1:0] ram_code;
	logic [LW-1:0]     ram_link;
	logic [LW-1:0]     link_eff;
	logic              link_nil;
	logic [LW-1:0]     accept_tgt;
	logic              tgt_nil;
	logic              head_nil;
	logic              free_nil;
	logic              walk_done;
	logic              sal_gt;
	logic              sal_eq;
	logic              tie_we;
	logic [NW-1:0]     tie_waddr;
	logic              tie_re;
	logic [LW-1:0]     tcnt_dec;
	logic [CODE_W-1:0] tie_rdata;
	logic              out_free;
	logic              emit_load;

	assign head_nil = (list_head_q >= NIL);
	assign free_nil = (free_head_q >= NIL);
	assign out_free = !out_valid_q || out_ready;

	assign ram_sal  = node_rdata[SAL_W-1:0];
	assign ram_code = node_rdata[SAL_W +: CODE_W];
	assign ram_link = node_rdata[SAL_W + CODE_W +: LW];

	// A node never written still holds its reset link to the next node.
	assign link_eff = rd_vld_s1 ? ram_link : (LW'(rd_node_s1) + LW'(1));
	assign link_nil = (link_eff >= NIL);

	assign accept_tgt = in_find ? list_head_q : free_head_q;
	assign tgt_nil    = (accept_tgt >= NIL);

	assign walk_done = link_nil || ((steps_q + LW'(1)) == NIL);

	assign node_re    = (cmd.accept && !tgt_nil) || (cmd.walk && !walk_done);
	assign node_raddr = cmd.accept ? accept_tgt[NW-1:0] : link_eff[NW-1:0];
	assign node_wdata = {list_head_q, code_q, sal_q};

	assign sal_gt = !have_q || (ram_sal > max_q);
	assign sal_eq = have_q && (ram_sal == max_q) && (tcnt_q < NIL);

	assign tie_we    = cmd.walk && (sal_gt || sal_eq);
	assign tie_waddr = sal_gt ? '0 : tcnt_q[NW-1:0];

	assign emit_load = cmd.emit && pend_q && out_free;
	assign tie_re    = cmd.emit && (tcnt_q != '0) && (!pend_q || emit_load);
	assign tcnt_dec  = tcnt_q - LW'(1);

	nplmq_ram #(
		.WIDTH (NRW),
		.DEPTH (POOL_NODES)
	) u_node_ram (
		.clk   (clk),
		.we    (cmd.ins_commit),
		.waddr (free_head_q[NW-1:0]),
		.wdata (node_wdata),
		.re    (node_re),
		.raddr (node_raddr),
		.rdata (node_rdata)
	);

	nplmq_ram #(
		.WIDTH (CODE_W),
		.DEPTH (POOL_NODES)
	) u_tie_ram (
		.clk   (clk),
		.we    (tie_we),
		.waddr (tie_waddr),
		.wdata (ram_code),
		.re    (tie_re),
		.raddr (tcnt_dec[NW-1:0]),
		.rdata (tie_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_head_q <= NIL;
			free_head_q <= '0;
			link_vld_q  <= '0;
		end else if (cmd.ins_commit) begin
			list_head_q                       <= free_head_q;
			free_head_q                       <= link_nil ? NIL : link_eff;
			link_vld_q[free_head_q[NW-1:0]]   <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			act_q      <= in_find;
			ins_full_q <= free_nil;
			code_q     <= in_code;
			sal_q      <= in_salary;
		end
		if (node_re) begin
			rd_node_s1 <= node_raddr;
			rd_vld_s1  <= link_vld_q[node_raddr];
		end
		if (cmd.walk && sal_gt) begin
			max_q <= ram_sal;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q     <= '0;
			have_q      <= 1'b0;
			tcnt_q      <= '0;
			pend_q      <= 1'b0;
			pend_last_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				steps_q <= '0;
				have_q  <= 1'b0;
				tcnt_q  <= '0;
			end else if (cmd.walk) begin
				steps_q <= steps_q + LW'(1);
				if (sal_gt) begin
					have_q <= 1'b1;
					tcnt_q <= LW'(1);
				end else if (sal_eq) begin
					tcnt_q <= tcnt_q + LW'(1);
				end
			end else if (tie_re) begin
				tcnt_q <= tcnt_dec;
			end

			if (tie_re) begin
				pend_q      <= 1'b1;
				pend_last_q <= (tcnt_dec == '0);
			end else if (emit_load) begin
				pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load || emit_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			if (act_q == ACT_FIND) begin
				out_status_q <= STAT_FIND;
				out_max_q    <= '1;
			end else begin
				out_status_q <= ins_full_q ? STAT_INS_FULL : STAT_INS_DONE;
				out_max_q    <= '0;
			end
			out_code_q       <= '0;
			out_code_valid_q <= 1'b0;
			out_list_empty_q <= head_nil;
			out_pool_full_q  <= free_nil;
			out_last_q       <= 1'b1;
		end else if (emit_load) begin
			out_status_q     <= STAT_FIND;
			out_max_q        <= $signed({1'b0, max_q});
			out_code_q       <= tie_rdata;
			out_code_valid_q <= 1'b1;
			out_list_empty_q <= head_nil;
			out_pool_full_q  <= free_nil;
			out_last_q       <= pend_last_q;
		end
	end

	always_comb begin
		st           = '0;
		st.in_find   = in_find;
		st.free_nil  = free_nil;
		st.head_nil  = head_nil;
		st.walk_done = walk_done;
		st.emit_done = emit_load && pend_last_q;
		st.out_free  = out_free;
	end

	assign out_valid      = out_valid_q;
	assign out_status     = out_status_q;
	assign out_max        = out_max_q;
	assign out_code       = out_code_q;
	assign out_code_valid = out_code_valid_q;
	assign out_list_empty = out_list_empty_q;
	assign out_pool_full  = out_pool_full_q;
	assign out_last       = out_last_q;

	`NPLMQ_ASSERT_IMP(a_load_into_free_reg, clk, arst_n, cmd.res_load || emit_load, !out_valid_q || out_ready)
	`NPLMQ_ASSERT_IMP(a_commit_has_free_node, clk, arst_n, cmd.ins_commit, free_head_q < NIL)
	`NPLMQ_ASSERT_NXT(a_commit_fills_list, clk, arst_n, cmd.ins_commit, list_head_q < NIL)
	`NPLMQ_ASSERT_IMP(a_heads_disjoint, clk, arst_n, list_head_q < NIL, list_head_q != free_head_q)
	`NPLMQ_ASSERT_IMP(a_walk_tracks_max, clk, arst_n, cmd.walk && (steps_q != '0), have_q)

endmodule

### rtl/core/node_pool_list_with_max_query.sv
// ----------------------------------------------------------------------------
// node_pool_list_with_max_query
// Node pool holding one linked list, with insert at the front and a
// maximum-salary query that returns every tying code.
// ----------------------------------------------------------------------------
// The block takes one transaction at a time and holds s_axis_tready low
// until that transaction's results are all in the output register. An insert
// steps through acceptance with the read of the free-list link, the node
// write, and the load of its single result. A find on an empty list goes
// from acceptance straight to the load of its result. A find on a list of N
// nodes walks the list, then emits one result per tying code, each after a
// read of the tie stack; the walk is paced by the node memory's single read
// port and the emission by the read port of the tie stack. Results are held
// in an output register, so the next transaction can be accepted while the
// last result waits on m_axis_tready. Reset needs no clearing pass: the
// initial free list comes from one valid bit per node.
module node_pool_list_with_max_query #(
	parameter int POOL_NODES = nplmq_pkg::DEF_POOL_NODES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // new_code[15:0], new_salary[39:16]
	input  logic [0:0]  s_axis_tuser,   // action[0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // max_salary[24:0], tie_code[40:25],
	                                    // list_empty[41], pool_full[42], zero
	output logic [2:0]  m_axis_tuser,   // status[1:0], code_valid[2]
	output logic        m_axis_tlast
);

	import nplmq_pkg::*;

	nplmq_cmd_t cmd;
	nplmq_st_t  st;

	logic [STAT_W-1:0]       out_status;
	logic signed [MAX_W-1:0] out_max;
	logic [CODE_W-1:0]       out_code;
	logic                    out_code_valid;
	logic                    out_list_empty;
	logic                    out_pool_full;

	nplmq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.st       (st),
		.cmd      (cmd)
	);

	nplmq_dp #(
		.POOL_NODES (POOL_NODES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.st             (st),
		.in_find        (s_axis_tuser[0]),
		.in_code        (s_axis_tdata[15:0]),
		.in_salary      (s_axis_tdata[39:16]),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.out_status     (out_status),
		.out_max        (out_max),
		.out_code       (out_code),
		.out_code_valid (out_code_valid),
		.out_list_empty (out_list_empty),
		.out_pool_full  (out_pool_full),
		.out_last       (m_axis_tlast)
	);

	assign m_axis_tdata = {5'b0, out_pool_full, out_list_empty, out_code, out_max};
	assign m_axis_tuser = {out_code_valid, out_status};

endmodule

### test/node_pool_list_with_max_query_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// node_pool_list_with_max_query_tb
// Self-checking bench for the node pool list with its maximum-salary query.
// The bench mirrors the pool and its list in a small tracker class. Each
// accepted request is applied to that copy, which queues the answers the
// block should return. Each answer the block hands over is checked against
// the oldest queued one. Both stream sides idle and stall at random, with
// calm stretches that have no gaps.
// ----------------------------------------------------------------------------
module node_pool_list_with_max_query_tb;
	import nplmq_pkg::*;

	localparam int POOL       = DEF_POOL_NODES;
	localparam int LINK_W     = $clog2(POOL + 1);
	localparam int RAND_ITEMS = 350;
	localparam int IDLE_LIMIT = 2000;
	localparam int DRAIN_WAIT = 40;
	localparam bit [LINK_W-1:0] NIL = LINK_W'(POOL);

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [MAX_W-1:0]  max_salary;
		logic [CODE_W-1:0] tie_code;
		logic              code_valid;
		logic              list_empty;
		logic              pool_full;
		logic              last;
	} pool_answer_t;

	class salary_pool_tracker;
		bit [LINK_W-1:0] next_link [POOL];
		bit [CODE_W-1:0] node_code [POOL];
		bit [SAL_W-1:0]  node_salary [POOL];
		bit [LINK_W-1:0] list_head;
		bit [LINK_W-1:0] free_head;
		pool_answer_t    pending_answers [$];
		int              errors;

		function new();
			for (int i = 0; i < POOL; i++)
				next_link[i] = LINK_W'(i + 1);
			list_head = NIL;
			free_head = '0;
			errors    = 0;
		endfunction

		function bit pool_exhausted();
			return free_head >= NIL;
		endfunction

		function void queue_answer(logic [STAT_W-1:0] status, logic [MAX_W-1:0] max_salary,
				logic [CODE_W-1:0] code, logic code_valid, logic last);
			pool_answer_t a;
			a.status     = status;
			a.max_salary = max_salary;
			a.tie_code   = code;
			a.code_valid = code_valid;
			a.list_empty = list_head >= NIL;
			a.pool_full  = free_head >= NIL;
			a.last       = last;
			pending_answers.push_back(a);
		endfunction

		function void apply_request(logic act, logic [CODE_W-1:0] code,
				logic [SAL_W-1:0] salary);
			bit [LINK_W-1:0] node;
			bit [LINK_W-1:0] cur;
			bit [CODE_W-1:0] ties [POOL];
			int best;
			int steps;
			int n;
			if (act == ACT_INSERT) begin
				node = free_head;
				if (node >= NIL) begin
					queue_answer(STAT_INS_FULL, '0, '0, 1'b0, 1'b1);
					return;
				end
				free_head = (next_link[node] > NIL) ? NIL : next_link[node];
				node_code[node]   = code;
				node_salary[node] = salary;
				next_link[node]   = list_head;
				list_head         = node;
				queue_answer(STAT_INS_DONE, '0, '0, 1'b0, 1'b1);
				return;
			end
			// Walk from the head; a larger salary restarts the tie stack.
			cur   = list_head;
			steps = 0;
			best  = -1;
			n     = 0;
			while (cur < NIL && steps < POOL) begin
				if (int'(node_salary[cur]) > best) begin
					best    = int'(node_salary[cur]);
					ties[0] = node_code[cur];
					n       = 1;
				end else if (int'(node_salary[cur]) == best && n < POOL) begin
					ties[n] = node_code[cur];
					n++;
				end
				cur = next_link[cur];
				steps++;
			end
			if (n == 0) begin
				queue_answer(STAT_FIND, '1, '0, 1'b0, 1'b1);
			end else begin
				for (int i = n - 1; i >= 0; i--)
					queue_answer(STAT_FIND, MAX_W'(best), ties[i], 1'b1, i == 0);
			end
		endfunction

		function void compare_field(string name, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				errors++;
				$error("%s mismatch: expected %0h, got %0h", name, want, got);
			end
		endfunction

		function void match_answer(logic [47:0] data, logic [2:0] user, logic tlast);
			pool_answer_t want;
			if (pending_answers.size() == 0) begin
				errors++;
				$error("result transaction with nothing expected, tdata %h", data);
				return;
			end
			want = pending_answers.pop_front();
			compare_field("status", want.status, user[1:0]);
			compare_field("max_salary", want.max_salary, data[24:0]);
			compare_field("tie_code", want.tie_code, data[40:25]);
			compare_field("code_valid", want.code_valid, user[2]);
			compare_field("list_empty", want.list_empty, data[41]);
			compare_field("pool_full", want.pool_full, data[42]);
			compare_field("last", want.last, tlast);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;
	logic [0:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;
	logic        m_axis_tlast;

	salary_pool_tracker tracker;
	bit calm;
	int stall_left;
	int idle_cycles;

	node_pool_list_with_max_query dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_request(input logic act, input logic [CODE_W-1:0] code,
			input logic [SAL_W-1:0] salary);
		int gap;
		gap = calm ? 0 : pick_gap();
		repeat (gap) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {salary, code};
		s_axis_tuser  <= act;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		tracker.apply_request(act, code, salary);
	endtask

	function automatic logic [SAL_W-1:0] pick_salary(bit all_top);
		if (all_top)
			return '1;
		case ($urandom_range(0, 3))
			0: return '1;
			1: return '0;
			2: return SAL_W'($urandom_range(1000, 1001));
			default: return SAL_W'($urandom);
		endcase
	endfunction

	// Receiver: random stalls on tready, no new ones while the stimulus is calm.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			m_axis_tready <= 1'b0;
			stall_left--;
		end else begin
			m_axis_tready <= 1'b1;
			if (!calm && $urandom_range(0, 2) == 0)
				stall_left = pick_gap();
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			tracker.match_answer(m_axis_tdata, m_axis_tuser, m_axis_tlast);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("node_pool_list_with_max_query_tb: FAIL");
				$finish;
			end
		end
	end

	initial begin
		bit all_top;
		bit act;
		tracker       = new();
		calm          = 1'b0;
		stall_left    = 0;
		idle_cycles   = 0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		m_axis_tready = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: query on an empty list, extreme codes, a two-way tie
		// returned oldest first, and a repeat query after the tie stack drains.
		send_request(ACT_FIND, 16'h0000, 24'h000000);
		send_request(ACT_INSERT, 16'hFFFF, 24'hFFFFFF);
		send_request(ACT_FIND, 16'hFFFF, 24'hFFFFFF);
		send_request(ACT_INSERT, 16'h0000, 24'hFFFFFF);
		send_request(ACT_FIND, 16'h0000, 24'h000000);
		send_request(ACT_FIND, 16'hFFFF, 24'hFFFFFF);

		// Random: the pool fills with queries mixed in, then further inserts
		// are refused. Sometimes every node ties at the top salary.
		all_top = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < RAND_ITEMS; i++) begin
			calm = ((i / 30) % 4 == 3);
			act  = $urandom_range(0, 1);
			if (!tracker.pool_exhausted() && act == ACT_INSERT)
				send_request(ACT_INSERT, CODE_W'($urandom_range(0, 65535)),
					pick_salary(all_top));
			else
				send_request(act, CODE_W'($urandom), SAL_W'($urandom));
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b0;

		while (tracker.pending_answers.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending_answers.size() == 0)
			$display("node_pool_list_with_max_query_tb: PASS");
		else
			$display("node_pool_list_with_max_query_tb: FAIL");
		$finish;
	end

endmodule
